### src/qfsp_pkg.sv
// Shared types, constants and weight tables of the quadratic-fit smoother and predictor.
package qfsp_pkg;

  // Filter length and tap index width
  localparam int TAPS  = 10;
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] LAST_TAP = IDX_W'(TAPS - 1);

  // Q1.15 weights
  localparam int COEF_W = 16;
  localparam int FRAC_W = 15;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_LOAD
  } qfsp_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             accept;
    logic             mac;
    logic             load;
    logic [IDX_W-1:0] tap;
  } qfsp_cmd_t;

  // Constant-term weights of the quadratic least-squares fit, newest sample first
  function automatic logic signed [COEF_W-1:0] wt_cur(input logic [IDX_W-1:0] tap);
    logic signed [COEF_W-1:0] w;
    case (tap)
      4'd0:    w = 16'sd20257;
      4'd1:    w = 16'sd12511;
      4'd2:    w = 16'sd6256;
      4'd3:    w = 16'sd1489;
      4'd4:    w = -16'sd1787;
      4'd5:    w = -16'sd3575;
      4'd6:    w = -16'sd3873;
      4'd7:    w = -16'sd2681;
      4'd8:    w = 16'sd0;
      4'd9:    w = 16'sd4170;
      default: w = 16'sd0;
    endcase
    return w;
  endfunction

  // Sum of constant, linear and quadratic weights: one-step-ahead prediction
  function automatic logic signed [COEF_W-1:0] wt_nxt(input logic [IDX_W-1:0] tap);
    logic signed [COEF_W-1:0] w;
    case (tap)
      4'd0:    w = 16'sd29492;
      4'd1:    w = 16'sd16383;
      4'd2:    w = 16'sd6008;
      4'd3:    w = -16'sd1638;
      4'd4:    w = -16'sd6553;
      4'd5:    w = -16'sd8738;
      4'd6:    w = -16'sd8192;
      4'd7:    w = -16'sd4915;
      4'd8:    w = 16'sd1092;
      4'd9:    w = 16'sd9830;
      default: w = 16'sd0;
    endcase
    return w;
  endfunction

endpackage

### src/qfsp_ctrl.sv
// Controller: sequences accept, ten multiply-accumulate steps and the output load.
module qfsp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qfsp_pkg::qfsp_cmd_t   cmd
);

  qfsp_pkg::qfsp_state_t              state_r, state_nxt;
  logic [qfsp_pkg::IDX_W-1:0]         tap_r, tap_nxt;
  logic                               out_valid_r, out_valid_nxt;

  // State, tap counter and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qfsp_pkg::ST_IDLE;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    cmd.tap       = tap_r;
    in_stall      = 1'b1;
    case (state_r)
      qfsp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          tap_nxt    = '0;
          state_nxt  = qfsp_pkg::ST_MAC;
        end
      end
      qfsp_pkg::ST_MAC: begin
        cmd.mac = 1'b1;
        tap_nxt = tap_r + 1'b1;
        if (tap_r == qfsp_pkg::LAST_TAP) begin
          state_nxt = qfsp_pkg::ST_LOAD;
        end
      end
      qfsp_pkg::ST_LOAD: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = qfsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = qfsp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### src/qfsp_dpath.sv
// Datapath: sample history ring, shared multiply-accumulate pair, rounding and output word.
module qfsp_dpath #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  qfsp_pkg::qfsp_cmd_t             cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]  in_sample,
  output logic signed [SAMPLE_WIDTH-1:0]  out_current_estimate,
  output logic signed [SAMPLE_WIDTH-1:0]  out_next_prediction
);

  localparam int IDX_W  = qfsp_pkg::IDX_W;
  localparam int PROD_W = SAMPLE_WIDTH + qfsp_pkg::COEF_W;
  // sum of absolute weights stays below 2^17, so 18 guard bits cover the sum
  localparam int ACC_W  = SAMPLE_WIDTH + 18;
  localparam int Q_W    = ACC_W - qfsp_pkg::FRAC_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(16384);
  localparam logic signed [Q_W-1:0]   QMAX =
    Q_W'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - longint'(1));
  localparam logic signed [Q_W-1:0]   QMIN =
    Q_W'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));

  logic signed [SAMPLE_WIDTH-1:0] hist_r   [qfsp_pkg::TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_nxt [qfsp_pkg::TAPS];
  logic [IDX_W-1:0]               wp_r, wp_nxt;
  logic [IDX_W-1:0]               rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]               wr_slot;
  logic signed [ACC_W-1:0]        acc_cur_r, acc_cur_nxt;
  logic signed [ACC_W-1:0]        acc_nxt_r, acc_nxt_nxt;
  logic signed [SAMPLE_WIDTH-1:0] cur_r, cur_nxt;
  logic signed [SAMPLE_WIDTH-1:0] pred_r, pred_nxt;
  logic signed [SAMPLE_WIDTH-1:0] tap_y;
  logic signed [PROD_W-1:0]       prod_cur;
  logic signed [PROD_W-1:0]       prod_nxt;

  // Round to nearest (ties up) and saturate to the sample width
  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] biased;
    logic signed [Q_W-1:0]   q;
    logic signed [SAMPLE_WIDTH-1:0] r;
    biased = acc + HALF;
    q      = biased[ACC_W-1:qfsp_pkg::FRAC_W];
    if (q > QMAX) begin
      r = QMAX[SAMPLE_WIDTH-1:0];
    end else if (q < QMIN) begin
      r = QMIN[SAMPLE_WIDTH-1:0];
    end else begin
      r = q[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

  // History and pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < qfsp_pkg::TAPS; i++) begin
        hist_r[i] <= '0;
      end
      wp_r <= '0;
    end else begin
      hist_r <= hist_nxt;
      wp_r   <= wp_nxt;
    end
  end

  // Accumulators, read index and output word
  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    acc_cur_r <= acc_cur_nxt;
    acc_nxt_r <= acc_nxt_nxt;
    cur_r     <= cur_nxt;
    pred_r    <= pred_nxt;
  end

  // Append the sample, walk backward from the newest slot, accumulate
  always_comb begin
    wr_slot = (wp_r > qfsp_pkg::LAST_TAP) ? '0 : wp_r;
    hist_nxt    = hist_r;
    wp_nxt      = wp_r;
    rd_idx_nxt  = rd_idx_r;
    acc_cur_nxt = acc_cur_r;
    acc_nxt_nxt = acc_nxt_r;
    cur_nxt     = cur_r;
    pred_nxt    = pred_r;

    tap_y    = hist_r[rd_idx_r];
    prod_cur = PROD_W'(tap_y) * PROD_W'(qfsp_pkg::wt_cur(cmd.tap));
    prod_nxt = PROD_W'(tap_y) * PROD_W'(qfsp_pkg::wt_nxt(cmd.tap));

    if (cmd.accept) begin
      hist_nxt[wr_slot] = in_sample;
      wp_nxt      = (wr_slot == qfsp_pkg::LAST_TAP) ? '0 : wr_slot + 1'b1;
      rd_idx_nxt  = wr_slot;
      acc_cur_nxt = '0;
      acc_nxt_nxt = '0;
    end
    if (cmd.mac) begin
      // wrap from slot zero back to the last slot
      rd_idx_nxt  = (rd_idx_r == '0) ? qfsp_pkg::LAST_TAP : rd_idx_r - 1'b1;
      acc_cur_nxt = acc_cur_r + ACC_W'(prod_cur);
      acc_nxt_nxt = acc_nxt_r + ACC_W'(prod_nxt);
    end
    if (cmd.load) begin
      cur_nxt  = round_sat(acc_cur_r);
      pred_nxt = round_sat(acc_nxt_r);
    end
  end

  assign out_current_estimate = cur_r;
  assign out_next_prediction  = pred_r;

endmodule

### src/quadratic_fit_smoother_predictor_top.sv
// Top level of the quadratic-fit smoother and one-step predictor.
//
// Each accepted sample word is written into a ten-slot history ring (all zero
// after reset) and then run through one shared pair of multiply-accumulate
// units, one tap per cycle, newest sample first: one sum with the Q1.15
// constant-term weights of a quadratic least-squares fit gives the current
// estimate, the other with the sum of all three weight sets gives the
// prediction one sample ahead. Both sums are rounded to nearest with ties
// toward plus infinity and saturated to SAMPLE_WIDTH bits. The result word is
// loaded into the output register by the load step that follows the ten MAC
// steps, and the input takes no new word until the whole pass (accept, ten MAC
// steps, load) is through, as set by the ten-step pass through the single MAC
// pair. A new sample word is taken while the previous result still waits in the
// output register; if that word is still stalled when the next pass ends, the
// load step waits for it and the input stays stalled.
module quadratic_fit_smoother_predictor_top #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]  in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]  out_current_estimate,
  output logic signed [SAMPLE_WIDTH-1:0]  out_next_prediction
);

  qfsp_pkg::qfsp_cmd_t cmd;

  // Sequencer
  qfsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic and storage
  qfsp_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_sample            (in_sample),
    .out_current_estimate (out_current_estimate),
    .out_next_prediction  (out_next_prediction)
  );

endmodule

### src/qfsp_checker.sv
// Port-level checker for the smoother/predictor, bound to the top level.
module qfsp_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic signed [SAMPLE_WIDTH-1:0]  in_sample,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [SAMPLE_WIDTH-1:0]  out_current_estimate,
  input logic signed [SAMPLE_WIDTH-1:0]  out_next_prediction
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_estimate)
      && $stable(out_next_prediction))
    else $error("stalled result word changed");

  // Block further input once a sample word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // A new result comes only after the full ten-tap pass
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall) && $past(in_stall, 10))
    else $error("result appeared before the accumulate pass finished");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input sample is known whenever it is offered
  a_sample_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_sample))
    else $error("offered sample word unknown");

endmodule

bind quadratic_fit_smoother_predictor_top qfsp_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_qfsp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .in_sample            (in_sample),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_current_estimate (out_current_estimate),
  .out_next_prediction  (out_next_prediction)
);
